### rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the polygon crossing count block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

   localparam int DEF_MAX_VERTICES = 256;
   localparam int DEF_COORD_BITS   = 16;

   localparam int            CROSS_W   = 9;
   localparam logic [8:0]    CROSS_MAX = 9'd511;
   // count reported for a point below the bounding box
   localparam int            BELOW_BOX_COUNT = 2;
   // a polygon needs this many vertices before it can be closed
   localparam int            MIN_CLOSE_COUNT = 2;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_CLOSE  = 2'd2,
      ACT_QUERY  = 2'd3
   } pcc_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } pcc_state_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } pcc_edge_status_type;

endpackage

`default_nettype wire

### rtl/pcc_cell.sv
// ----------------------------------------------------------------------------
// pcc_cell
// One vertex slot of the rotating vertex ring.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_cell #(
   parameter int W = pcc_pkg::DEF_COORD_BITS
) (
   input  wire logic         clock,
   input  wire logic         wr_en,
   input  wire logic [W-1:0] wr_x,
   input  wire logic [W-1:0] wr_y,
   input  wire logic         shift_en,
   input  wire logic [W-1:0] nb_x,
   input  wire logic [W-1:0] nb_y,
   output logic      [W-1:0] x_out,
   output logic      [W-1:0] y_out
);

   logic [W-1:0] x_ff;
   logic [W-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_ff <= wr_x;
         y_ff <= wr_y;
      end else if (shift_en) begin
         x_ff <= nb_x;
         y_ff <= nb_y;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

`default_nettype wire

### rtl/pcc_edge_eval.sv
// ----------------------------------------------------------------------------
// pcc_edge_eval
// Three-stage edge test: does the edge straddle the point's column and pass
// strictly above the point. Exact cross-multiplied compare, no division.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_edge_eval #(
   parameter int W = pcc_pkg::DEF_COORD_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         edge_valid,
   input  wire logic [W-1:0] xa,
   input  wire logic [W-1:0] ya,
   input  wire logic [W-1:0] xb,
   input  wire logic [W-1:0] yb,
   input  wire logic [W-1:0] px,
   input  wire logic [W-1:0] py,
   output pcc_pkg::pcc_edge_status_type status
);

   localparam int PW = 2 * W;

   // stage 1: ordered end points
   logic         v1_ff;
   logic [W-1:0] lx_ff, ly_ff, rx_ff, ry_ff, px_ff, py_ff;
   // stage 2: differences
   logic         v2_ff;
   logic [W-1:0] dx_ff, ox_ff, m1_ff, m2_ff;
   logic         n1_ff, n2_ff;
   // stage 3: products
   logic          v3_ff;
   logic [PW-1:0] p1_ff, p2_ff;
   logic          s3n1_ff, s3n2_ff;

   logic         swap;
   logic         straddle;
   logic         neg1, neg2;
   logic         greater;

   assign swap     = xa > xb;
   assign straddle = (lx_ff <= px_ff) && (px_ff < rx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= edge_valid;
         // drop edges that miss the point's column
         v2_ff <= v1_ff && straddle;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      lx_ff <= swap ? xb : xa;
      ly_ff <= swap ? yb : ya;
      rx_ff <= swap ? xa : xb;
      ry_ff <= swap ? ya : yb;
      px_ff <= px;
      py_ff <= py;

      dx_ff <= rx_ff - lx_ff;
      ox_ff <= px_ff - lx_ff;
      n1_ff <= py_ff < ly_ff;
      m1_ff <= (py_ff < ly_ff) ? (ly_ff - py_ff) : (py_ff - ly_ff);
      n2_ff <= ry_ff < ly_ff;
      m2_ff <= (ry_ff < ly_ff) ? (ly_ff - ry_ff) : (ry_ff - ly_ff);

      p1_ff   <= PW'(m1_ff) * PW'(dx_ff);
      p2_ff   <= PW'(m2_ff) * PW'(ox_ff);
      s3n1_ff <= n1_ff;
      s3n2_ff <= n2_ff;
   end

   // signed compare of (py-ya)*dx against (px-xa)*(yb-ya); zero has no sign
   always_comb begin
      neg1 = s3n1_ff && (p1_ff != '0);
      neg2 = s3n2_ff && (p2_ff != '0);
      if (neg1 != neg2) begin
         greater = neg2;
      end else if (neg1) begin
         greater = p1_ff < p2_ff;
      end else begin
         greater = p1_ff > p2_ff;
      end
   end

   assign status.busy = v1_ff || v2_ff || v3_ff;
   assign status.hit  = v3_ff && greater;

endmodule

`default_nettype wire

### rtl/polygon_crossing_count.sv
// Clear and append do not leave the idle state, so the block is ready again next cycle.
// Close walks the vertex ring once, then passes through the drain state back to idle.
// Query: a point outside or below the box, or an open polygon, goes straight to done;
// otherwise the query walks the ring once, drains the edge test, then writes the result.
// One request is in work at a time; the result register frees the input side.
// Reset clears count, closed flag and box; vertex slots keep old contents.
// ----------------------------------------------------------------------------
// polygon_crossing_count
// Crossing-number point-in-polygon test over one stored polygon held in a
// rotating ring of vertex cells, with one shared edge test at the ring head.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_crossing_count #(
   parameter int MAX_VERTICES = pcc_pkg::DEF_MAX_VERTICES,
   parameter int COORD_BITS   = pcc_pkg::DEF_COORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_action,
   input  wire logic [COORD_BITS-1:0] req_coord_x,
   input  wire logic [COORD_BITS-1:0] req_coord_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [pcc_pkg::CROSS_W-1:0] rsp_crossings,
   output logic                       rsp_inside_res,
   output logic                       rsp_below
);

   localparam int W     = COORD_BITS;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SAT_W = (CNT_W > pcc_pkg::CROSS_W) ? CNT_W : pcc_pkg::CROSS_W;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_VERTICES);

   pcc_pkg::pcc_state_type state_ff, state_in;
   pcc_pkg::pcc_action_type action;

   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic             closed_ff, closed_in;
   logic             is_query_ff, is_query_in;
   logic [W-1:0]     left_ff, left_in, top_ff, top_in;
   logic [W-1:0]     right_ff, right_in, bottom_ff, bottom_in;
   logic [W-1:0]     qx_ff, qx_in, qy_ff, qy_in;
   logic [W-1:0]     first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [W-1:0]     prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pcc_pkg::CROSS_W-1:0] rsp_crossings_ff, rsp_crossings_in;
   logic                        rsp_inside_ff, rsp_inside_in;
   logic                        rsp_below_ff, rsp_below_in;

   logic [W-1:0] cell_x [MAX_VERTICES];
   logic [W-1:0] cell_y [MAX_VERTICES];
   logic [W-1:0] head_x, head_y;

   logic         req_accept;
   logic         append_ok;
   logic         walking;
   logic         shift_en;
   logic         in_poly;
   logic         edge_valid;
   logic [W-1:0] edge_bx, edge_by;
   logic         out_free;
   logic         outside_box;
   logic         below_box;
   logic [SAT_W-1:0] hits_wide;
   pcc_pkg::pcc_edge_status_type edge_status;

   assign action     = pcc_pkg::pcc_action_type'(req_action);
   assign req_stall  = state_ff != pcc_pkg::ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign append_ok  = req_accept && (action == pcc_pkg::ACT_APPEND) && !closed_ff
                       && (count_ff < CNT_W'(MAX_VERTICES));
   assign walking    = state_ff == pcc_pkg::ST_WALK;
   assign shift_en   = walking && (step_ff != LAST_STEP);
   assign in_poly    = step_ff < count_ff;
   assign head_x     = cell_x[0];
   assign head_y     = cell_y[0];

   // ring of vertex cells; each step moves the next vertex to the head
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_VERTICES;
      pcc_cell #(.W(W)) u_cell (
         .clock   (clock),
         .wr_en   (append_ok && (count_ff == CNT_W'(i))),
         .wr_x    (req_coord_x),
         .wr_y    (req_coord_y),
         .shift_en(shift_en),
         .nb_x    (cell_x[NEXT]),
         .nb_y    (cell_y[NEXT]),
         .x_out   (cell_x[i]),
         .y_out   (cell_y[i])
      );
   end

   // edge from previous vertex to head; once past the last vertex, close to the first
   assign edge_valid = walking && is_query_ff
                       && ((in_poly && (step_ff != '0)) || (step_ff == count_ff));
   assign edge_bx    = in_poly ? head_x : first_x_ff;
   assign edge_by    = in_poly ? head_y : first_y_ff;

   pcc_edge_eval #(.W(W)) u_edge (
      .clock     (clock),
      .reset     (reset),
      .edge_valid(edge_valid),
      .xa        (prev_x_ff),
      .ya        (prev_y_ff),
      .xb        (edge_bx),
      .yb        (edge_by),
      .px        (qx_ff),
      .py        (qy_ff),
      .status    (edge_status)
   );

   assign outside_box = !closed_ff || (req_coord_x < left_ff) || (req_coord_x > right_ff)
                        || (req_coord_y < top_ff);
   assign below_box   = req_coord_y > bottom_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign hits_wide   = SAT_W'(hits_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcc_pkg::ST_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         left_ff      <= '0;
         top_ff       <= '0;
         right_ff     <= '0;
         bottom_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff          <= step_in;
      hits_ff          <= hits_in;
      is_query_ff      <= is_query_in;
      qx_ff            <= qx_in;
      qy_ff            <= qy_in;
      first_x_ff       <= first_x_in;
      first_y_ff       <= first_y_in;
      prev_x_ff        <= prev_x_in;
      prev_y_ff        <= prev_y_in;
      rsp_crossings_ff <= rsp_crossings_in;
      rsp_inside_ff    <= rsp_inside_in;
      rsp_below_ff     <= rsp_below_in;
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      count_in         = count_ff;
      hits_in          = hits_ff;
      closed_in        = closed_ff;
      is_query_in      = is_query_ff;
      left_in          = left_ff;
      top_in           = top_ff;
      right_in         = right_ff;
      bottom_in        = bottom_ff;
      qx_in            = qx_ff;
      qy_in            = qy_ff;
      first_x_in       = first_x_ff;
      first_y_in       = first_y_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_crossings_in = rsp_crossings_ff;
      rsp_inside_in    = rsp_inside_ff;
      rsp_below_in     = rsp_below_ff;

      unique case (state_ff)
         pcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (action)
                  pcc_pkg::ACT_CLEAR: begin
                     count_in  = '0;
                     closed_in = 1'b0;
                     left_in   = '0;
                     top_in    = '0;
                     right_in  = '0;
                     bottom_in = '0;
                  end
                  pcc_pkg::ACT_APPEND: begin
                     if (append_ok) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pcc_pkg::ACT_CLOSE: begin
                     if (count_ff >= CNT_W'(pcc_pkg::MIN_CLOSE_COUNT)) begin
                        closed_in = 1'b1;
                     end
                     left_in     = '0;
                     top_in      = '0;
                     right_in    = '0;
                     bottom_in   = '0;
                     step_in     = '0;
                     is_query_in = 1'b0;
                     state_in    = pcc_pkg::ST_WALK;
                  end
                  pcc_pkg::ACT_QUERY: begin
                     qx_in       = req_coord_x;
                     qy_in       = req_coord_y;
                     step_in     = '0;
                     is_query_in = 1'b1;
                     hits_in     = '0;
                     if (outside_box) begin
                        state_in = pcc_pkg::ST_DONE;
                     end else if (below_box) begin
                        hits_in  = CNT_W'(pcc_pkg::BELOW_BOX_COUNT);
                        state_in = pcc_pkg::ST_DONE;
                     end else begin
                        state_in = pcc_pkg::ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pcc_pkg::ST_WALK: begin
            if (edge_status.hit) begin
               hits_in = hits_ff + 1'b1;
            end
            if (in_poly) begin
               prev_x_in = head_x;
               prev_y_in = head_y;
               if (step_ff == '0) begin
                  first_x_in = head_x;
                  first_y_in = head_y;
               end
               if (!is_query_ff) begin
                  if ((step_ff == '0) || (head_x < left_ff)) left_in = head_x;
                  if ((step_ff == '0) || (head_y < top_ff))  top_in  = head_y;
                  if (head_x > right_ff)  right_in  = head_x;
                  if (head_y > bottom_ff) bottom_in = head_y;
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in = pcc_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         pcc_pkg::ST_DRAIN: begin
            if (edge_status.hit) begin
               hits_in = hits_ff + 1'b1;
            end
            if (!edge_status.busy) begin
               state_in = is_query_ff ? pcc_pkg::ST_DONE : pcc_pkg::ST_IDLE;
            end
         end
         pcc_pkg::ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_crossings_in = (hits_wide > SAT_W'(pcc_pkg::CROSS_MAX))
                                  ? pcc_pkg::CROSS_MAX : hits_wide[pcc_pkg::CROSS_W-1:0];
               rsp_inside_in    = hits_ff[0];
               rsp_below_in     = !hits_ff[0] && (hits_ff != '0);
               state_in         = pcc_pkg::ST_IDLE;
            end
         end
         default: state_in = pcc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crossings  = rsp_crossings_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_below      = rsp_below_ff;

endmodule

`default_nettype wire

### rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the polygon crossing count block.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [8:0] rsp_crossings,
   input wire logic       rsp_inside_res,
   input wire logic       rsp_below
);

   // a result is never flagged both inside and below
   a_inside_below_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inside_res && rsp_below))
      else $error("result flagged inside and below at once");

   // below means a non-zero count
   a_below_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_below) |-> (rsp_crossings != 9'd0))
      else $error("below flagged with zero crossings");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // clear and append finish in the cycle they are taken
   a_single_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall
       && ((req_action == pcc_pkg::ACT_CLEAR) || (req_action == pcc_pkg::ACT_APPEND)))
      |=> !req_stall)
      else $error("clear or append request held the input side");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_crossings)))
      else $error("stalled result changed");

endmodule

bind polygon_crossing_count pcc_checker u_pcc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_crossings (rsp_crossings),
   .rsp_inside_res(rsp_inside_res),
   .rsp_below     (rsp_below)
);

`default_nettype wire

### verif/tb_polygon_crossing_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_crossing_count
// Loads polygons vertex by vertex, closes them and fires point queries at the
// block. A built-in crossing counter predicts every query result and a
// monitor checks each field. Both channels idle and stall at random, and the
// receiver holds off for long stretches to back the block up.
// ----------------------------------------------------------------------------

module tb_polygon_crossing_count;

   localparam int MAX_VERT     = pcc_pkg::DEF_MAX_VERTICES;
   localparam int COORD_W      = pcc_pkg::DEF_COORD_BITS;
   localparam int CROSS_W      = pcc_pkg::CROSS_W;
   localparam int COORD_TOP    = (1 << COORD_W) - 1;
   localparam int REQ_TARGET   = 1150;
   localparam int CYCLE_LIMIT  = 1200000;
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD    = 1200;
   localparam int HOLD_AT_A    = 30;
   localparam int HOLD_AT_B    = 200;

   typedef struct {
      pcc_pkg::pcc_action_type action;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
      int                      gap;
   } poly_req_type;

   typedef struct packed {
      logic [CROSS_W-1:0] crossings;
      logic               inside_res;
      logic               below;
   } verdict_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action = pcc_pkg::ACT_CLEAR;
   logic [COORD_W-1:0]  req_coord_x = '0;
   logic [COORD_W-1:0]  req_coord_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CROSS_W-1:0]  rsp_crossings;
   logic                rsp_inside_res;
   logic                rsp_below;

   polygon_crossing_count i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crossings  (rsp_crossings),
      .rsp_inside_res (rsp_inside_res),
      .rsp_below      (rsp_below)
   );

   // stimulus and scoreboard state
   poly_req_type pending[$];
   verdict_type  verdicts[$];
   bit        gen_calm;
   int        reqs_total;
   int        reqs_accepted = 0;
   int        results_seen = 0;
   int        fail_count = 0;
   int        cycle_count = 0;
   int        req_gap_left = 0;
   int        rsp_wait = 0;
   bit        rsp_long = 1'b0;
   bit        req_took = 1'b0;
   bit        rsp_took = 1'b0;

   // shadow of the polygon store
   logic [COORD_W-1:0] ring_x [MAX_VERT];
   logic [COORD_W-1:0] ring_y [MAX_VERT];
   int                 ring_count = 0;
   bit                 ring_closed = 1'b0;
   logic [COORD_W-1:0] bb_left = '0, bb_top = '0, bb_right = '0, bb_bottom = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Count edges that straddle the point's column and pass above it; the
   // slope compare is cross-multiplied so it stays exact.
   function automatic int count_edges_above(logic [COORD_W-1:0] px,
                                             logic [COORD_W-1:0] py);
      int     hits;
      int     prev;
      int     k;
      longint xa, ya, xb, yb, t, lpx, lpy;
      hits = 0;
      prev = ring_count - 1;
      lpx  = px;
      lpy  = py;
      for (k = 0; k < ring_count; k++) begin
         xa = ring_x[prev];
         ya = ring_y[prev];
         xb = ring_x[k];
         yb = ring_y[k];
         if (xa > xb) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
         end
         if (xa <= lpx && lpx < xb) begin
            if ((lpy - ya) * (xb - xa) > (lpx - xa) * (yb - ya))
               hits++;
         end
         prev = k;
      end
      return hits;
   endfunction

   // Advance the shadow polygon by one accepted request; queue a verdict for
   // every query.
   function automatic void track_request(poly_req_type r);
      verdict_type v;
      int          hits;
      int          k;
      case (r.action)
         pcc_pkg::ACT_CLEAR: begin
            ring_count  = 0;
            ring_closed = 1'b0;
            bb_left = '0; bb_top = '0; bb_right = '0; bb_bottom = '0;
         end
         pcc_pkg::ACT_APPEND: begin
            if (!ring_closed && ring_count < MAX_VERT) begin
               ring_x[ring_count] = r.x;
               ring_y[ring_count] = r.y;
               ring_count++;
            end
         end
         pcc_pkg::ACT_CLOSE: begin
            if (ring_count >= pcc_pkg::MIN_CLOSE_COUNT)
               ring_closed = 1'b1;
            bb_left = '0; bb_top = '0; bb_right = '0; bb_bottom = '0;
            for (k = 0; k < ring_count; k++) begin
               if (k == 0 || ring_x[k] < bb_left)  bb_left  = ring_x[k];
               if (k == 0 || ring_y[k] < bb_top)   bb_top   = ring_y[k];
               if (ring_x[k] > bb_right)           bb_right = ring_x[k];
               if (ring_y[k] > bb_bottom)          bb_bottom = ring_y[k];
            end
         end
         default: begin
            if (!ring_closed || r.x < bb_left || r.x > bb_right || r.y < bb_top)
               hits = 0;
            else if (r.y > bb_bottom)
               hits = pcc_pkg::BELOW_BOX_COUNT;
            else
               hits = count_edges_above(r.x, r.y);
            v.crossings  = (hits > pcc_pkg::CROSS_MAX) ? pcc_pkg::CROSS_MAX
                                                       : hits[CROSS_W-1:0];
            v.inside_res = hits[0];
            v.below      = !hits[0] && (hits != 0);
            verdicts     = {verdicts, v};
         end
      endcase
   endfunction

   task automatic queue_req(pcc_pkg::pcc_action_type act, int x, int y);
      poly_req_type r;
      r.action = act;
      r.x      = x[COORD_W-1:0];
      r.y      = y[COORD_W-1:0];
      r.gap    = gen_calm ? 0 : $urandom_range(0, 6);
      pending  = {pending, r};
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin : watch_channels
      poly_req_type seen;
      verdict_type  want;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            seen.action = pcc_pkg::pcc_action_type'(req_action);
            seen.x      = req_coord_x;
            seen.y      = req_coord_y;
            seen.gap    = 0;
            track_request(seen);
            reqs_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (verdicts.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d/%0b/%0b",
                        $time, rsp_crossings, rsp_inside_res, rsp_below);
               fail_count++;
            end else begin
               want = verdicts.pop_front();
               if (rsp_crossings !== want.crossings) begin
                  $display("%0t: crossings mismatch: expected %0d actual %0d",
                           $time, want.crossings, rsp_crossings);
                  fail_count++;
               end
               if (rsp_inside_res !== want.inside_res) begin
                  $display("%0t: inside_res mismatch: expected %0b actual %0b",
                           $time, want.inside_res, rsp_inside_res);
                  fail_count++;
               end
               if (rsp_below !== want.below) begin
                  $display("%0t: below mismatch: expected %0b actual %0b",
                           $time, want.below, rsp_below);
                  fail_count++;
               end
            end
         end
      end
   end

   // request driver: hold the payload until accepted, then idle for the drawn gap
   always @(negedge clock) begin : drive_requests
      poly_req_type nxt;
      if (!reset) begin
         if (!req_valid || req_took) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               nxt = pending.pop_front();
               req_action   <= nxt.action;
               req_coord_x  <= nxt.x;
               req_coord_y  <= nxt.y;
               req_gap_left = nxt.gap;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: short random stalls, calm stretches, two long hold-offs
   always @(negedge clock) begin : stall_results
      if (!reset) begin
         if (rsp_took) begin
            if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
               rsp_wait = LONG_HOLD;
               rsp_long = 1'b1;
            end else if ((results_seen / 40) % 4 == 1) begin
               rsp_wait = 0;
            end else begin
               rsp_wait = $urandom_range(0, 6);
            end
         end else if (rsp_wait > 0 && (rsp_valid || rsp_long)) begin
            rsp_wait--;
         end
         if (rsp_wait == 0)
            rsp_long = 1'b0;
         rsp_stall <= (rsp_wait != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int u_x[8];
      int u_y[8];
      int kind, span, base_x, base_y, nv, nq, i, j;
      int vx, vy, lx, rx, ty, by, qx, qy, lo, hi;
      int seq_x[$];
      int seq_y[$];

      u_x = '{0, 40, 40, 30, 30, 10, 10, 0};
      u_y = '{5, 5, 35, 35, 15, 15, 35, 35};

      // directed: open polygon, short close, extreme square, U shape
      gen_calm = 1'b0;
      queue_req(pcc_pkg::ACT_QUERY, 0, 0);
      queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
      queue_req(pcc_pkg::ACT_APPEND, 0, 0);
      queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
      queue_req(pcc_pkg::ACT_QUERY, 0, 0);
      queue_req(pcc_pkg::ACT_APPEND, COORD_TOP, 0);
      queue_req(pcc_pkg::ACT_APPEND, COORD_TOP, COORD_TOP);
      queue_req(pcc_pkg::ACT_APPEND, 0, COORD_TOP);
      queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
      queue_req(pcc_pkg::ACT_CLOSE, COORD_TOP, COORD_TOP);
      queue_req(pcc_pkg::ACT_APPEND, 100, 100);
      queue_req(pcc_pkg::ACT_QUERY, 32768, 32768);
      queue_req(pcc_pkg::ACT_QUERY, COORD_TOP, COORD_TOP);
      queue_req(pcc_pkg::ACT_CLEAR, 0, 0);
      for (i = 0; i < 8; i++)
         queue_req(pcc_pkg::ACT_APPEND, u_x[i], u_y[i]);
      queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
      queue_req(pcc_pkg::ACT_QUERY, 20, 25);
      queue_req(pcc_pkg::ACT_QUERY, 5, 25);
      queue_req(pcc_pkg::ACT_QUERY, 20, 36);
      queue_req(pcc_pkg::ACT_QUERY, 41, 10);
      queue_req(pcc_pkg::ACT_QUERY, 20, 2);

      while (pending.size() < REQ_TARGET) begin
         kind     = $urandom_range(0, 8);
         gen_calm = ($urandom_range(0, 3) == 0);
         if (kind <= 6) begin
            // random polygon, then a burst of queries around its box
            case ($urandom_range(0, 2))
               0:       span = $urandom_range(1, 16);
               1:       span = $urandom_range(17, 2000);
               default: span = COORD_TOP;
            endcase
            base_x = $urandom_range(0, COORD_TOP - span);
            base_y = $urandom_range(0, COORD_TOP - span);
            nv = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262)
                                               : $urandom_range(2, 12);
            queue_req(pcc_pkg::ACT_CLEAR, $urandom_range(0, COORD_TOP),
                      $urandom_range(0, COORD_TOP));
            seq_x.delete();
            seq_y.delete();
            lx = COORD_TOP; rx = 0; ty = COORD_TOP; by = 0;
            for (i = 0; i < nv; i++) begin
               vx = base_x + $urandom_range(0, span);
               vy = base_y + $urandom_range(0, span);
               if (i < MAX_VERT) begin
                  if (vx < lx) lx = vx;
                  if (vx > rx) rx = vx;
                  if (vy < ty) ty = vy;
                  if (vy > by) by = vy;
               end
               seq_x = {seq_x, vx};
               seq_y = {seq_y, vy};
               queue_req(pcc_pkg::ACT_APPEND, vx, vy);
            end
            queue_req(pcc_pkg::ACT_CLOSE, $urandom_range(0, COORD_TOP),
                      $urandom_range(0, COORD_TOP));
            if ($urandom_range(0, 4) == 0)
               queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
            if ($urandom_range(0, 4) == 0)
               queue_req(pcc_pkg::ACT_APPEND, $urandom_range(0, COORD_TOP),
                         $urandom_range(0, COORD_TOP));
            nq = $urandom_range(3, 10);
            for (i = 0; i < nq; i++) begin
               lo = (lx >= 2) ? lx - 2 : 0;
               hi = (rx + 2 > COORD_TOP) ? COORD_TOP : rx + 2;
               qx = $urandom_range(lo, hi);
               lo = (ty >= 2) ? ty - 2 : 0;
               hi = (by + 3 > COORD_TOP) ? COORD_TOP : by + 3;
               qy = $urandom_range(lo, hi);
               case ($urandom_range(0, 5))
                  3: begin
                     // land on a vertex column or a vertex exactly
                     j  = $urandom_range(0, seq_x.size() - 1);
                     qx = seq_x[j];
                     if ($urandom_range(0, 1) == 0) qy = seq_y[j];
                  end
                  4: begin
                     qx = $urandom_range(0, COORD_TOP);
                     qy = $urandom_range(0, COORD_TOP);
                  end
                  5: qy = ($urandom_range(0, 1) == 0) ? ty : by;
                  default: ;
               endcase
               queue_req(pcc_pkg::ACT_QUERY, qx, qy);
            end
         end else if (kind == 7) begin
            // noise: any action, any coordinates
            nq = $urandom_range(4, 12);
            for (i = 0; i < nq; i++)
               queue_req(pcc_pkg::pcc_action_type'($urandom_range(0, 3)),
                         $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
         end else begin
            // broken sequence: too few vertices to close, or never closed
            queue_req(pcc_pkg::ACT_CLEAR, 0, 0);
            nv = $urandom_range(0, 3);
            for (i = 0; i < nv; i++)
               queue_req(pcc_pkg::ACT_APPEND, $urandom_range(0, 64), $urandom_range(0, 64));
            if (nv < pcc_pkg::MIN_CLOSE_COUNT)
               queue_req(pcc_pkg::ACT_CLOSE, 0, 0);
            nq = $urandom_range(1, 3);
            for (i = 0; i < nq; i++)
               queue_req(pcc_pkg::ACT_QUERY, $urandom_range(0, 64), $urandom_range(0, 64));
         end
      end
      reqs_total = pending.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (reqs_accepted < reqs_total)
         @(negedge clock);
      while (verdicts.size() != 0)
         @(negedge clock);
      // leave room for any stray result to show up
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/pcc_pkg.sv
rtl/pcc_cell.sv
rtl/pcc_edge_eval.sv
rtl/polygon_crossing_count.sv
rtl/pcc_checker.sv
verif/tb_polygon_crossing_count.sv
